// File: sv/vpa_pkg.sv
// Shared types and constants of the variable partition allocator.
// Depends on nothing; every other file of the block refers to it.
package vpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 16;
    localparam int SIZE_W     = ADDR_BITS + 1;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OWNER_W    = 8;
    localparam int CMD_W      = 2;
    localparam int POL_W      = 2;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SIZE_W-1:0] MEM_CAP = SIZE_W'(1) << ADDR_BITS;
    localparam logic [CNT_W-1:0]  TABLE_DEPTH = CNT_W'(MAX_BLOCKS);

    // command codes
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // fit policy codes
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = 1'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_FIT   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NO_OWNER = 3'd3,
        ST_BAD      = 3'd4
    } status_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic [OWNER_W-1:0]   owner;
    } entry_t;

    localparam entry_t RESET_ENTRY = '{start: '0, size: MEM_CAP, owner: '0};

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_WR_TAIL,
        OP_WR_HEAD,
        OP_REL_INIT,
        OP_REL_RD,
        OP_REL_EV,
        OP_REL_END,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             owner_zero;
        logic             req_zero;
        logic             idx_end;
        logic             first_stop;
        logic             found;
        logic             exact;
        logic             full;
        logic             shift_end;
        logic             hit;
        logic             out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_SCAN_END,
        S_SH_RD,
        S_SH_WR,
        S_WR_TAIL,
        S_WR_HEAD,
        S_REL_RD,
        S_REL_EV,
        S_DONE
    } state_t;

endpackage

// File: sv/vpa_in_if.sv
// Request channel of the allocator: valid, ready and one command item.
// Depends on vpa_pkg for field widths.
interface vpa_in_if;
    logic                         valid;
    logic                         ready;
    logic [vpa_pkg::CMD_W-1:0]    command;
    logic [vpa_pkg::OWNER_W-1:0]  owner_id;
    logic [vpa_pkg::SIZE_W-1:0]   request_size;

    modport source (output valid, output command, output owner_id, output request_size,
                    input ready);
    modport sink   (input valid, input command, input owner_id, input request_size,
                    output ready);
endinterface

// File: sv/vpa_out_if.sv
// Result channel of the allocator: valid, ready and one result item.
// Depends on vpa_pkg for field widths.
interface vpa_out_if;
    logic                           valid;
    logic                           ready;
    logic [2:0]                     status;
    logic [vpa_pkg::ADDR_BITS-1:0]  block_address;
    logic [vpa_pkg::SIZE_W-1:0]     block_size;

    modport source (output valid, output status, output block_address, output block_size,
                    input ready);
    modport sink   (input valid, input status, input block_address, input block_size,
                    output ready);
endinterface

// File: sv/vpa_ctrl.sv
// Controller of the allocator: sequences scan, shift and merge passes.
// Depends on vpa_pkg; drives the datapath through ctrl_cmd_t.
module vpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vpa_pkg::dp_stat_t   stat,
    output vpa_pkg::ctrl_cmd_t  cmd
);
    import vpa_pkg::*;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    // hold state and pending result code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.op      = OP_NONE;
        cmd.status  = status_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.cmd == CMD_INIT)
                begin
                    state_next = S_INIT;
                end
                else if (stat.cmd == CMD_ALLOC && !stat.owner_zero && !stat.req_zero)
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_SCAN_RD;
                end
                else if (stat.cmd == CMD_RELEASE && !stat.owner_zero)
                begin
                    cmd.op     = OP_REL_INIT;
                    state_next = S_REL_RD;
                end
                else
                begin
                    status_next = ST_BAD;
                    state_next  = S_DONE;
                end
            end
            S_INIT:
            begin
                cmd.op      = OP_INIT;
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_SCAN_RD:
            begin
                if (stat.idx_end)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                cmd.op     = OP_SCAN_EV;
                state_next = stat.first_stop ? S_SCAN_END : S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                if (!stat.found)
                begin
                    status_next = ST_NO_FIT;
                    state_next  = S_DONE;
                end
                else if (stat.exact)
                begin
                    state_next = S_WR_HEAD;
                end
                else if (stat.full)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SH_INIT;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (stat.shift_end)
                begin
                    state_next = S_WR_TAIL;
                end
                else
                begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.op     = OP_SH_WR;
                state_next = S_SH_RD;
            end
            S_WR_TAIL:
            begin
                cmd.op     = OP_WR_TAIL;
                state_next = S_WR_HEAD;
            end
            S_WR_HEAD:
            begin
                cmd.op      = OP_WR_HEAD;
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_REL_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.op      = OP_REL_END;
                    status_next = stat.hit ? ST_OK : ST_NO_OWNER;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_REL_RD;
                    state_next = S_REL_EV;
                end
            end
            S_REL_EV:
            begin
                cmd.op     = OP_REL_EV;
                state_next = S_REL_RD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/vpa_datapath.sv
// Datapath of the allocator: block table memory, scan and merge registers,
// configuration registers and the result register. Depends on vpa_pkg.
module vpa_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vpa_pkg::ctrl_cmd_t                 cmd,
    output vpa_pkg::dp_stat_t                  stat,
    input  logic [vpa_pkg::CMD_W-1:0]          in_command,
    input  logic [vpa_pkg::OWNER_W-1:0]        in_owner_id,
    input  logic [vpa_pkg::SIZE_W-1:0]         in_request_size,
    input  logic                               cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpa_pkg::SIZE_W-1:0]         cfg_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [2:0]                         out_status,
    output logic [vpa_pkg::ADDR_BITS-1:0]      out_block_address,
    output logic [vpa_pkg::SIZE_W-1:0]         out_block_size
);
    import vpa_pkg::*;

    entry_t mem [MAX_BLOCKS];

    logic [POL_W-1:0]     fit_policy_reg;
    logic [SIZE_W-1:0]    memory_size_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [OWNER_W-1:0]   owner_reg;
    logic [SIZE_W-1:0]    req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [CNT_W-1:0]     w_reg;
    logic                 found_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [ADDR_BITS-1:0] pick_start_reg;
    logic [SIZE_W-1:0]    pick_size_reg;
    logic [SIZE_W-1:0]    freed_reg;
    entry_t               hold_reg;
    logic                 fresh_reg;
    logic                 rd_fresh_reg;
    entry_t               rd_q_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [SIZE_W-1:0]    out_size_reg;

    entry_t               rd_entry;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic                 cand;
    logic [OWNER_W-1:0]   rel_owner;
    logic                 merge;
    logic [SIZE_W-1:0]    tail_start_sum;
    logic [CNT_W-1:0]     pick_next_idx;
    logic [SIZE_W-1:0]    init_units;
    logic                 is_best;
    logic                 is_worst;

    // table entry read, with entry 0 seen as the reset hole until written
    assign rd_entry = rd_fresh_reg ? RESET_ENTRY : rd_q_reg;

    assign is_best        = (fit_policy_reg == POL_BEST);
    assign is_worst       = (fit_policy_reg == POL_WORST);
    assign cand           = (rd_entry.owner == '0) && (rd_entry.size >= req_reg);
    assign rel_owner      = (rd_entry.owner == owner_reg) ? '0 : rd_entry.owner;
    assign merge          = (w_reg != '0) && (rel_owner == '0) && (hold_reg.owner == '0);
    assign tail_start_sum = {1'b0, pick_start_reg} + req_reg;
    assign pick_next_idx  = {1'b0, pick_reg} + CNT_W'(1);

    // saturate the managed size into one .. full address space
    always_comb
    begin
        if (memory_size_reg == '0)
            init_units = SIZE_W'(1);
        else if (memory_size_reg > MEM_CAP)
            init_units = MEM_CAP;
        else
            init_units = memory_size_reg;
    end

    // memory address and write data selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_entry;
        case (cmd.op)
            OP_SCAN_RD, OP_REL_RD:
            begin
                rd_en = 1'b1;
            end
            OP_SH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(j_reg - CNT_W'(1));
            end
            OP_SH_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[IDX_W-1:0];
            end
            OP_WR_TAIL:
            begin
                wr_en         = 1'b1;
                wr_addr       = pick_next_idx[IDX_W-1:0];
                wr_data.start = tail_start_sum[ADDR_BITS-1:0];
                wr_data.size  = pick_size_reg - req_reg;
                wr_data.owner = '0;
            end
            OP_WR_HEAD:
            begin
                wr_en         = 1'b1;
                wr_addr       = pick_reg;
                wr_data.start = pick_start_reg;
                wr_data.size  = req_reg;
                wr_data.owner = owner_reg;
            end
            OP_INIT:
            begin
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data.start = '0;
                wr_data.size  = init_units;
                wr_data.owner = '0;
            end
            OP_REL_EV:
            begin
                wr_en = 1'b1;
                if (merge)
                begin
                    wr_addr       = IDX_W'(w_reg - CNT_W'(1));
                    wr_data.start = hold_reg.start;
                    wr_data.size  = hold_reg.size + rd_entry.size;
                    wr_data.owner = '0;
                end
                else
                begin
                    wr_addr       = w_reg[IDX_W-1:0];
                    wr_data.start = rd_entry.start;
                    wr_data.size  = rd_entry.size;
                    wr_data.owner = rel_owner;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // table memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= mem[rd_addr];
    end

    // track whether entry 0 still holds its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg    <= 1'b1;
            rd_fresh_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_addr == '0)
                fresh_reg <= 1'b0;
            if (rd_en)
                rd_fresh_reg <= fresh_reg && (rd_addr == '0);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg  <= POL_FIRST;
            memory_size_reg <= MEM_CAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:  fit_policy_reg  <= cfg_data[POL_W-1:0];
                CFG_MEMORY_SIZE: memory_size_reg <= cfg_data;
                default:         fit_policy_reg  <= fit_policy_reg;
            endcase
        end
    end

    // table count and pass counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            idx_reg   <= '0;
            j_reg     <= '0;
            w_reg     <= '0;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_INIT:
                begin
                    count_reg <= CNT_W'(1);
                end
                OP_SCAN_INIT:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                OP_SCAN_EV:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (cand)
                        found_reg <= 1'b1;
                end
                OP_SH_INIT:
                begin
                    j_reg <= count_reg;
                end
                OP_SH_WR:
                begin
                    j_reg <= j_reg - CNT_W'(1);
                end
                OP_WR_HEAD:
                begin
                    if (pick_size_reg != req_reg)
                        count_reg <= count_reg + CNT_W'(1);
                end
                OP_REL_INIT:
                begin
                    idx_reg <= '0;
                    w_reg   <= '0;
                    hit_reg <= 1'b0;
                end
                OP_REL_EV:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (!merge)
                        w_reg <= w_reg + CNT_W'(1);
                    if (rd_entry.owner == owner_reg)
                        hit_reg <= 1'b1;
                end
                OP_REL_END:
                begin
                    count_reg <= w_reg;
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // item capture, chosen hole, merge hold and freed sum
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                cmd_reg   <= in_command;
                owner_reg <= in_owner_id;
                req_reg   <= in_request_size;
            end
            OP_SCAN_EV:
            begin
                if (cand && (!found_reg
                             || (is_best && rd_entry.size < pick_size_reg)
                             || (is_worst && rd_entry.size > pick_size_reg)))
                begin
                    pick_reg       <= idx_reg[IDX_W-1:0];
                    pick_start_reg <= rd_entry.start;
                    pick_size_reg  <= rd_entry.size;
                end
            end
            OP_REL_INIT:
            begin
                freed_reg <= '0;
            end
            OP_REL_EV:
            begin
                hold_reg <= wr_data;
                if (rd_entry.owner == owner_reg)
                    freed_reg <= freed_reg + rd_entry.size;
            end
            default:
            begin
                freed_reg <= freed_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_EMIT)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
        begin
            out_status_reg <= cmd.status;
            out_addr_reg   <= '0;
            out_size_reg   <= '0;
            if (cmd.status == ST_OK && cmd_reg == CMD_ALLOC)
            begin
                out_addr_reg <= pick_start_reg;
                out_size_reg <= req_reg;
            end
            else if (cmd.status == ST_OK && cmd_reg == CMD_RELEASE)
            begin
                out_size_reg <= freed_reg;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_block_address = out_addr_reg;
    assign out_block_size    = out_size_reg;

    // status toward the controller
    always_comb
    begin
        stat.cmd        = cmd_reg;
        stat.owner_zero = (owner_reg == '0);
        stat.req_zero   = (req_reg == '0);
        stat.idx_end    = (idx_reg == count_reg);
        stat.first_stop = cand && !found_reg && !is_best && !is_worst;
        stat.found      = found_reg;
        stat.exact      = (pick_size_reg == req_reg);
        stat.full       = (count_reg >= TABLE_DEPTH);
        stat.shift_end  = (j_reg == pick_next_idx);
        stat.hit        = hit_reg;
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule

// File: sv/variable_partition_allocator_top.sv
// One item at a time; the table memory port sets the pace.
// Next item accepted in the same cycle as the result appears in the output register.
// Reset: one hole spanning 65536 units, first fit, no clearing pass.
// Top level of the allocator; depends on vpa_pkg, vpa_in_if, vpa_out_if,
// vpa_ctrl and vpa_datapath.
module variable_partition_allocator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    vpa_in_if.sink                            in_item,
    vpa_out_if.source                         out_item,
    input  logic                              cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vpa_pkg::SIZE_W-1:0]        cfg_data
);
    import vpa_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequence each item
    vpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table and result datapath
    vpa_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_command        (in_item.command),
        .in_owner_id       (in_item.owner_id),
        .in_request_size   (in_item.request_size),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_item.valid),
        .out_ready         (out_item.ready),
        .out_status        (out_item.status),
        .out_block_address (out_item.block_address),
        .out_block_size    (out_item.block_size)
    );

endmodule

// File: bench/vpa_checker.sv
// Checker of the allocator: watches the request, result and register-write ports,
// predicts each result from its own copy of the block table and compares them.
// Depends on vpa_pkg, vpa_in_if and vpa_out_if.
module vpa_checker
    import vpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    vpa_in_if                    in_mon,
    vpa_out_if                   out_mon,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   result_count,
    output int                   full_count,
    output int                   nofit_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t              status;
        logic [ADDR_BITS-1:0] addr;
        logic [SIZE_W-1:0]    size;
    } grant_t;

    // shadow of the block table and the registers
    logic [ADDR_BITS-1:0] blk_start [MAX_BLOCKS];
    logic [SIZE_W-1:0]    blk_size  [MAX_BLOCKS];
    logic [OWNER_W-1:0]   blk_owner [MAX_BLOCKS];
    int                   blk_count;
    logic [POL_W-1:0]     policy;
    logic [SIZE_W-1:0]    mem_units;

    grant_t grants_due [$];

    assign pending = grants_due.size();

    function automatic void rebuild_table(logic [SIZE_W-1:0] units);
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            blk_start[i] = '0;
            blk_size[i]  = '0;
            blk_owner[i] = '0;
        end
        blk_size[0] = units;
        blk_count   = 1;
    endfunction

    function automatic grant_t allocate(logic [OWNER_W-1:0] owner, logic [SIZE_W-1:0] req);
        grant_t g;
        int     pick;
        bit     found;
        g = '{ST_BAD, '0, '0};
        pick  = 0;
        found = 0;
        if (owner == 0 || req == 0)
            return g;
        // pick a hole; ties go to the lowest address
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_owner[i] != 0 || blk_size[i] < req)
                continue;
            if (!found)
            begin
                found = 1;
                pick  = i;
                if (policy != POL_BEST && policy != POL_WORST)
                    break;
            end
            else if (policy == POL_BEST && blk_size[i] < blk_size[pick])
                pick = i;
            else if (policy == POL_WORST && blk_size[i] > blk_size[pick])
                pick = i;
        end
        if (!found)
        begin
            g.status = ST_NO_FIT;
            return g;
        end
        // split off the remainder as a new hole right after the grant
        if (blk_size[pick] != req)
        begin
            if (blk_count >= MAX_BLOCKS)
            begin
                g.status = ST_FULL;
                return g;
            end
            for (int j = blk_count - 1; j > pick; j--)
            begin
                blk_start[j+1] = blk_start[j];
                blk_size[j+1]  = blk_size[j];
                blk_owner[j+1] = blk_owner[j];
            end
            blk_start[pick+1] = blk_start[pick] + req[ADDR_BITS-1:0];
            blk_size[pick+1]  = blk_size[pick] - req;
            blk_owner[pick+1] = '0;
            blk_size[pick]    = req;
            blk_count++;
        end
        blk_owner[pick] = owner;
        g = '{ST_OK, blk_start[pick], req};
        return g;
    endfunction

    function automatic grant_t release_owner(logic [OWNER_W-1:0] owner);
        grant_t            g;
        logic [SIZE_W-1:0] freed;
        bit                hit;
        int                w;
        g = '{ST_BAD, '0, '0};
        freed = '0;
        hit   = 0;
        w     = 0;
        if (owner == 0)
            return g;
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_owner[i] == owner)
            begin
                blk_owner[i] = '0;
                freed += blk_size[i];
                hit = 1;
            end
        end
        if (!hit)
        begin
            g.status = ST_NO_OWNER;
            return g;
        end
        // merge neighboring holes while compacting the table
        for (int i = 0; i < blk_count; i++)
        begin
            if (w > 0 && blk_owner[i] == 0 && blk_owner[w-1] == 0)
                blk_size[w-1] += blk_size[i];
            else
            begin
                blk_start[w] = blk_start[i];
                blk_size[w]  = blk_size[i];
                blk_owner[w] = blk_owner[i];
                w++;
            end
        end
        for (int i = w; i < MAX_BLOCKS; i++)
        begin
            blk_start[i] = '0;
            blk_size[i]  = '0;
            blk_owner[i] = '0;
        end
        blk_count = w;
        g = '{ST_OK, '0, freed};
        return g;
    endfunction

    function automatic grant_t predict_command(logic [CMD_W-1:0] cmd, logic [OWNER_W-1:0] owner,
                                               logic [SIZE_W-1:0] req);
        grant_t            g;
        logic [SIZE_W-1:0] units;
        g = '{ST_BAD, '0, '0};
        if (cmd == CMD_INIT)
        begin
            units = mem_units;
            if (units == 0)
                units = 1;
            if (units > MEM_CAP)
                units = MEM_CAP;
            rebuild_table(units);
            g.status = ST_OK;
        end
        else if (cmd == CMD_ALLOC)
            g = allocate(owner, req);
        else if (cmd == CMD_RELEASE)
            g = release_owner(owner);
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // track registers, predict accepted items, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy    <= POL_FIRST;
            mem_units <= MEM_CAP;
            rebuild_table(MEM_CAP);
            grants_due.delete();
            fail_count   <= 0;
            result_count <= 0;
            full_count   <= 0;
            nofit_count  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIT_POLICY)
                    policy <= cfg_data[POL_W-1:0];
                else if (cfg_index == CFG_MEMORY_SIZE)
                    mem_units <= cfg_data;
            end
            if (in_mon.valid && in_mon.ready)
                grants_due.push_back(predict_command(in_mon.command, in_mon.owner_id,
                                                     in_mon.request_size));
            if (out_mon.valid && out_mon.ready)
            begin
                grant_t want;
                result_count <= result_count + 1;
                if (grants_due.size() == 0)
                begin
                    $display("[%0t] result item with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (want.status == ST_FULL)
                        full_count <= full_count + 1;
                    if (want.status == ST_NO_FIT)
                        nofit_count <= nofit_count + 1;
                    if (out_mon.status !== want.status)
                        report_mismatch("status", out_mon.status, want.status);
                    if (out_mon.block_address !== want.addr)
                        report_mismatch("block_address", out_mon.block_address, want.addr);
                    if (out_mon.block_size !== want.size)
                        report_mismatch("block_size", out_mon.block_size, want.size);
                end
            end
        end
    end
endmodule

// File: bench/tb_top.sv
// Top of the allocator testbench: clock, reset, request and register stimulus,
// result back-pressure, watchdog and verdict. Depends on vpa_pkg, the channel
// interfaces, variable_partition_allocator_top and vpa_checker.
module tb_top;
    import vpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL  = 1550;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 600;

    // codes outside the defined sets
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [POL_W-1:0] POL_UNUSED  = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    int                   fail_count, pending, result_count, full_count, nofit_count;
    int                   items_sent;
    int                   idle_cycles;
    bit                   hold_req;

    vpa_in_if  in_ch ();
    vpa_out_if out_ch ();

    variable_partition_allocator_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch),
        .out_item (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    vpa_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .pending     (pending),
        .result_count(result_count),
        .full_count  (full_count),
        .nofit_count (nofit_count)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [OWNER_W-1:0] owner,
                             logic [SIZE_W-1:0] req);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.owner_id     <= owner;
        in_ch.request_size <= req;
        forever
        begin
            @(negedge clk);
            if (in_ch.ready)
                break;
        end
        @(posedge clk);
        items_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for all results, then write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [SIZE_W-1:0] pick_units();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 40;
            4, 5:    return SIZE_W'($urandom_range(60, 300));
            6:       return SIZE_W'($urandom_range(300, 5000));
            7:       return 65535;
            8:       return MEM_CAP;
            9:       return 17'h1FFFF;
            default: return SIZE_W'($urandom_range(1, 200));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_request(logic [SIZE_W-1:0] units);
        int span;
        int r;
        span = (units > MEM_CAP) ? MEM_CAP : ((units == 0) ? 1 : units);
        r = $urandom_range(0, 99);
        if (r < 70)
            return SIZE_W'($urandom_range(1, (span / 24 > 1) ? span / 24 : 1));
        if (r < 88)
            return SIZE_W'($urandom_range(1, span));
        if (r < 92)
            return 0;
        if (r < 96)
            return MEM_CAP;
        return SIZE_W'($urandom_range(0, 17'h1FFFF));
    endfunction

    function automatic logic [OWNER_W-1:0] pick_owner();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return OWNER_W'($urandom_range(1, 14));
        if (r < 90)
            return 0;
        if (r < 94)
            return 255;
        return OWNER_W'($urandom_range(0, 255));
    endfunction

    // result side back-pressure, with long hold-offs
    initial
    begin
        int mode;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    hold_req = 0;
                end
                if (mode == 0)
                    out_ch.ready <= 1'b1;
                else if (mode == 1)
                    out_ch.ready <= ($urandom_range(0, 99) < 60);
                else
                    out_ch.ready <= (gap_len() == 0);
            end
        end
    end

    // end the run if nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [SIZE_W-1:0] units;
        int                r;
        rst_n              = 1'b0;
        hold_req           = 0;
        items_sent         = 0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_FIT_POLICY;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_INIT;
        in_ch.owner_id     = '0;
        in_ch.request_size = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full memory taken whole, then error answers
        send_item(CMD_ALLOC, 8'd1, MEM_CAP);
        send_item(CMD_ALLOC, 8'd2, 17'd1);
        send_item(CMD_RELEASE, 8'd0, 17'd0);
        send_item(CMD_RELEASE, 8'd3, 17'd5);
        send_item(CMD_RELEASE, 8'd1, 17'd0);
        send_item(CMD_ALLOC, 8'd4, 17'd0);
        send_item(CMD_ALLOC, 8'd0, 17'd9);
        send_item(CMD_UNKNOWN, 8'd255, 17'h1FFFF);
        send_item(CMD_ALLOC, 8'd255, 17'h1FFFF);
        // memory size zero acts as one unit
        write_reg(CFG_MEMORY_SIZE, 17'd0);
        send_item(CMD_INIT, 8'd0, 17'd0);
        send_item(CMD_ALLOC, 8'd7, 17'd1);
        // best fit ties and repeat owners
        write_reg(CFG_MEMORY_SIZE, 17'd100);
        write_reg(CFG_FIT_POLICY, SIZE_W'(POL_BEST));
        send_item(CMD_INIT, 8'd0, 17'd0);
        send_item(CMD_ALLOC, 8'd1, 17'd10);
        send_item(CMD_ALLOC, 8'd2, 17'd20);
        send_item(CMD_ALLOC, 8'd1, 17'd10);
        send_item(CMD_ALLOC, 8'd3, 17'd30);
        send_item(CMD_ALLOC, 8'd4, 17'd10);
        send_item(CMD_RELEASE, 8'd1, 17'd0);
        send_item(CMD_ALLOC, 8'd5, 17'd4);
        // worst fit, then unused policy code
        write_reg(CFG_FIT_POLICY, SIZE_W'(POL_WORST));
        send_item(CMD_ALLOC, 8'd6, 17'd3);
        write_reg(CFG_FIT_POLICY, SIZE_W'(POL_UNUSED));
        send_item(CMD_ALLOC, 8'd6, 17'd2);
        // oversized memory saturates
        write_reg(CFG_MEMORY_SIZE, 17'h1FFFF);
        send_item(CMD_INIT, 8'd0, 17'd0);

        // random phases, each under its own setting
        while (items_sent < ITEM_GOAL)
        begin
            units = pick_units();
            write_reg(CFG_FIT_POLICY, SIZE_W'($urandom_range(0, 3)));
            write_reg(CFG_MEMORY_SIZE, units);
            send_item(CMD_INIT, pick_owner(), pick_request(units));
            repeat ($urandom_range(40, 90))
            begin
                if (items_sent > 500 && items_sent < 520)
                    hold_req = 1;
                r = $urandom_range(0, 99);
                if (r < 64)
                    send_item(CMD_ALLOC, pick_owner(), pick_request(units));
                else if (r < 94)
                    send_item(CMD_RELEASE, pick_owner(), pick_request(units));
                else if (r < 97)
                    send_item(CMD_INIT, pick_owner(), pick_request(units));
                else
                    send_item(CMD_UNKNOWN, pick_owner(), pick_request(units));
            end
        end

        // drain
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("covered %0d requests and %0d results over all fit policies and sizes",
                 items_sent, result_count);
        $display("answers seen: %0d table full, %0d no fitting hole", full_count, nofit_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
